// File: hdl/ffba_pkg.sv
// Shared types and codes for the first-fit block allocator.
// Used by ffba_hdr_store and first_fit_block_allocator_top.
package ffba_pkg;

	typedef enum logic [1:0] {
		TAG_NONE = 2'd0,
		TAG_FREE = 2'd1,
		TAG_USED = 2'd2
	} tag_t;

	localparam logic       KIND_ALLOC = 1'b0;
	localparam logic       KIND_FREE  = 1'b1;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_ZERO    = 3'd1;
	localparam logic [2:0] ST_NOMEM   = 3'd2;
	localparam logic [2:0] ST_RANGE   = 3'd3;
	localparam logic [2:0] ST_BADFREE = 3'd4;

	localparam int unsigned UNIT_SHIFT = 4;

	typedef struct packed {
		logic        kind;
		logic [31:0] request_bytes;
		logic [31:0] payload_offset;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] granted_offset;
		logic [16:0] granted_bytes;
		logic [16:0] in_use_bytes;
		logic [16:0] peak_bytes;
		logic [31:0] alloc_total;
		logic [31:0] free_total;
	} rsp_t;

endpackage

// File: hdl/ffba_hdr_store.sv
// Block header memory: one entry per unit, registered read, one write port.
// Runs a clearing sweep after reset. Depends on ffba_pkg.
module ffba_hdr_store #(
	parameter int ARENA_UNITS = 4096,
	parameter int AW = 12,
	parameter int DW = 15
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata,
	output logic          busy
);
	localparam int CW = $clog2(ARENA_UNITS + 1);

	logic [DW-1:0] mem [ARENA_UNITS];
	logic [DW-1:0] rdata_q;
	logic [CW-1:0] clr_q;
	logic          m_we;
	logic [AW-1:0] m_addr;
	logic [DW-1:0] m_data;

	assign busy = (clr_q < CW'(ARENA_UNITS));

	always_comb begin
		if (busy) begin
			m_we   = 1'b1;
			m_addr = clr_q[AW-1:0];
			if (clr_q == '0) begin
				m_data = {ffba_pkg::TAG_FREE, (DW-2)'(ARENA_UNITS)};
			end else begin
				m_data = {ffba_pkg::TAG_NONE, (DW-2)'(0)};
			end
		end else begin
			m_we   = we;
			m_addr = waddr;
			m_data = wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (busy) begin
			clr_q <= clr_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (m_we) begin
			mem[m_addr] <= m_data;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/first_fit_block_allocator_top.sv
// First-fit allocator over a header-tagged unit arena; top level.
// Alloc walks block headers to the first fit; free retags the block and then runs
// a merge pass that joins free runs. Rejected requests go straight to the result.
// One request at a time; the walk rate is set by the registered header read port.
// After reset a clearing sweep holds req_stall high until the header store is cleared.
// Depends on ffba_pkg and ffba_hdr_store.
module first_fit_block_allocator_top #(
	parameter int ARENA_UNITS = 4096
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  ffba_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output ffba_pkg::rsp_t rsp
);
	localparam int AW = (ARENA_UNITS > 1) ? $clog2(ARENA_UNITS) : 1;
	localparam int UW = $clog2(ARENA_UNITS + 1);
	localparam int SW = UW;
	localparam int DW = SW + 2;
	localparam int BW = UW + ffba_pkg::UNIT_SHIFT;
	localparam int unsigned ARENA_BYTES = ARENA_UNITS * 16;

	typedef struct packed {
		ffba_pkg::tag_t tag;
		logic [SW-1:0]  size;
	} hdr_t;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_A_WAIT, S_A_CHK, S_A_MARK, S_F_WAIT, S_F_CHK,
		S_M_WAIT, S_M_CHK, S_N_WAIT, S_N_CHK, S_OUT
	} state_t;

	state_t        state_q;
	logic [UW-1:0] u_q;
	logic [UW-1:0] base_q;
	logic [SW-1:0] acc_q;
	logic [SW-1:0] blk_q;
	logic [28:0]   need_q;
	logic [2:0]    status_q;
	logic [15:0]   goff_q;
	logic [BW-1:0] gbytes_q;
	logic [BW-1:0] used_q;
	logic [BW-1:0] peak_q;
	logic [31:0]   alloc_q;
	logic [31:0]   free_q;

	logic          hdr_we;
	logic [AW-1:0] hdr_waddr;
	hdr_t          hdr_wdata;
	hdr_t          hdr_rd;
	logic          hdr_busy;

	logic          fit;
	logic [SW-1:0] left;
	logic          split;
	logic          in_range;
	logic          run_more;
	logic [32:0]   round_up;
	logic [BW-1:0] blk_bytes;
	logic [BW-1:0] used_add;

	ffba_hdr_store #(
		.ARENA_UNITS(ARENA_UNITS),
		.AW(AW),
		.DW(DW)
	) u_store (
		.clk(clk),
		.arst_n(arst_n),
		.we(hdr_we),
		.waddr(hdr_waddr),
		.wdata(hdr_wdata),
		.raddr(u_q[AW-1:0]),
		.rdata(hdr_rd),
		.busy(hdr_busy)
	);

	assign in_range  = (u_q < UW'(ARENA_UNITS));
	assign fit       = (hdr_rd.tag == ffba_pkg::TAG_FREE) &&
	                   (32'(hdr_rd.size) >= 32'(need_q));
	assign left      = hdr_rd.size - need_q[SW-1:0];
	assign split     = (left >= SW'(2));
	assign run_more  = in_range && (hdr_rd.tag == ffba_pkg::TAG_FREE);
	assign round_up  = 33'(req.request_bytes) + 33'd15;
	assign blk_bytes = BW'({blk_q, 4'b0000});
	assign used_add  = used_q + blk_bytes;

	always_comb begin
		hdr_we    = 1'b0;
		hdr_waddr = u_q[AW-1:0];
		hdr_wdata = hdr_t'{tag: ffba_pkg::TAG_NONE, size: '0};
		case (state_q)
			S_A_CHK: begin
				if (in_range && hdr_rd.size != '0 && fit && split) begin
					hdr_we    = 1'b1;
					hdr_waddr = AW'(u_q + need_q[UW-1:0]);
					hdr_wdata = hdr_t'{tag: ffba_pkg::TAG_FREE, size: left};
				end
			end
			S_A_MARK: begin
				hdr_we    = 1'b1;
				hdr_wdata = hdr_t'{tag: ffba_pkg::TAG_USED, size: blk_q};
			end
			S_F_CHK: begin
				if (hdr_rd.tag == ffba_pkg::TAG_USED) begin
					hdr_we    = 1'b1;
					hdr_wdata = hdr_t'{tag: ffba_pkg::TAG_FREE, size: hdr_rd.size};
				end
			end
			S_N_CHK: begin
				hdr_we = 1'b1;
				if (!run_more) begin
					hdr_waddr = base_q[AW-1:0];
					hdr_wdata = hdr_t'{tag: ffba_pkg::TAG_FREE, size: acc_q};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			used_q   <= '0;
			peak_q   <= '0;
			alloc_q  <= '0;
			free_q   <= '0;
			u_q      <= '0;
			base_q   <= '0;
			acc_q    <= '0;
			blk_q    <= '0;
			need_q   <= '0;
			status_q <= ffba_pkg::ST_OK;
			goff_q   <= '0;
			gbytes_q <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (!hdr_busy) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req_valid) begin
						status_q <= ffba_pkg::ST_OK;
						goff_q   <= '0;
						gbytes_q <= '0;
						u_q      <= '0;
						need_q   <= 29'(round_up[32:4]) + 29'd1;
						if (req.kind == ffba_pkg::KIND_ALLOC) begin
							if (req.request_bytes == '0) begin
								status_q <= ffba_pkg::ST_ZERO;
								state_q  <= S_OUT;
							end else begin
								state_q <= S_A_WAIT;
							end
						end else if (req.payload_offset < 32'd16 ||
						             req.payload_offset >= 32'(ARENA_BYTES)) begin
							status_q <= ffba_pkg::ST_RANGE;
							state_q  <= S_OUT;
						end else if (req.payload_offset[3:0] != 4'd0) begin
							status_q <= ffba_pkg::ST_BADFREE;
							state_q  <= S_OUT;
						end else begin
							u_q     <= req.payload_offset[UW+3:4] - UW'(1);
							state_q <= S_F_WAIT;
						end
					end
				end
				S_A_WAIT: state_q <= S_A_CHK;
				S_A_CHK: begin
					if (!in_range || hdr_rd.size == '0) begin
						status_q <= ffba_pkg::ST_NOMEM;
						state_q  <= S_OUT;
					end else if (fit) begin
						blk_q   <= split ? need_q[SW-1:0] : hdr_rd.size;
						state_q <= S_A_MARK;
					end else begin
						u_q     <= u_q + hdr_rd.size;
						state_q <= S_A_WAIT;
					end
				end
				S_A_MARK: begin
					gbytes_q <= blk_bytes;
					goff_q   <= 16'({u_q + UW'(1), 4'b0000});
					used_q   <= used_add;
					if (used_add > peak_q) peak_q <= used_add;
					if (alloc_q != '1) alloc_q <= alloc_q + 32'd1;
					state_q  <= S_OUT;
				end
				S_F_WAIT: state_q <= S_F_CHK;
				S_F_CHK: begin
					if (hdr_rd.tag != ffba_pkg::TAG_USED) begin
						status_q <= ffba_pkg::ST_BADFREE;
						state_q  <= S_OUT;
					end else begin
						gbytes_q <= BW'({hdr_rd.size, 4'b0000});
						if (used_q >= BW'({hdr_rd.size, 4'b0000})) begin
							used_q <= used_q - BW'({hdr_rd.size, 4'b0000});
						end
						if (free_q != '1) free_q <= free_q + 32'd1;
						u_q     <= '0;
						state_q <= S_M_WAIT;
					end
				end
				S_M_WAIT: state_q <= S_M_CHK;
				S_M_CHK: begin
					if (!in_range || hdr_rd.size == '0) begin
						state_q <= S_OUT;
					end else if (hdr_rd.tag == ffba_pkg::TAG_FREE) begin
						base_q  <= u_q;
						acc_q   <= hdr_rd.size;
						u_q     <= u_q + hdr_rd.size;
						state_q <= S_N_WAIT;
					end else begin
						u_q     <= u_q + hdr_rd.size;
						state_q <= S_M_WAIT;
					end
				end
				S_N_WAIT: state_q <= S_N_CHK;
				S_N_CHK: begin
					if (run_more) begin
						acc_q   <= acc_q + hdr_rd.size;
						u_q     <= u_q + hdr_rd.size;
						state_q <= S_N_WAIT;
					end else begin
						state_q <= S_M_WAIT;
					end
				end
				S_OUT: begin
					if (!rsp_stall) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = (state_q == S_OUT);

	always_comb begin
		rsp.status         = status_q;
		rsp.granted_offset = goff_q;
		rsp.granted_bytes  = 17'(32'(gbytes_q));
		rsp.in_use_bytes   = 17'(32'(used_q));
		rsp.peak_bytes     = 17'(32'(peak_q));
		rsp.alloc_total    = alloc_q;
		rsp.free_total     = free_q;
	end

	a_peak_ge_used: assert property (@(posedge clk) disable iff (!arst_n)
		peak_q >= used_q)
		else $error("peak below in-use count");

	a_err_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status_q != ffba_pkg::ST_OK |-> goff_q == '0 && gbytes_q == '0)
		else $error("error beat carries a grant");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> req_stall)
		else $error("request taken while result pending");

	a_idle_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_stall |=> !req_stall && !rsp_valid)
		else $error("not idle after result beat");

endmodule
